FILE: hw/rtl/lfbd_pkg.sv
// lfbd_pkg: shared types and constants for the length framed byte deframer
// no dependencies; imported by length_framed_byte_deframer_unit
`default_nettype none

package lfbd_pkg;

    // result kind carried in tuser bits 1:0
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } kind_t;

    // deframer states
    typedef enum logic [1:0] {
        ST_HEAD   = 2'd0,
        ST_LEN_LO = 2'd1,
        ST_LEN_HI = 2'd2,
        ST_BODY   = 2'd3
    } state_t;

    // register word indexes (byte address / 4)
    localparam logic [1:0] REG_HEAD_PATTERN = 2'd0;
    localparam logic [1:0] REG_TAIL_VALUE   = 2'd1;
    localparam logic [1:0] REG_MIN_LENGTH   = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH   = 2'd3;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned TUSER_W  = 8;

    localparam logic [LEN_W-1:0] MIN_LENGTH_RST = 16'd2;
    localparam logic [LEN_W-1:0] MAX_LENGTH_RST = 16'hFFFF;

endpackage

`default_nettype wire

FILE: hw/rtl/length_framed_byte_deframer_unit.sv
// length_framed_byte_deframer_unit: head / length / tail frame deframer, top level
// depends on lfbd_pkg
//
// Takes one received byte per word and gives at most one result word per byte, at
// a sustained rate of one byte per clock while s_tready is high: each step is a
// single compare-and-count pass from input handshake to result register. The block
// hunts for the HEAD_BYTES-byte head given by head_pattern (first byte in bits 7:0), then reads a
// 16-bit little-endian length L that counts payload plus one tail byte. Lengths of
// zero or outside min_length..max_length send it back to hunting with no result.
// The L-1 following bytes come out as payload (tuser kind 0, first byte flagged,
// last byte with tlast), then the tail byte gives an end word of kind good or bad
// carrying the received tail byte in tdata. A mismatching head byte is consumed
// and not retried as a first head byte. A two-entry output stage (result register
// plus skid register) keeps s_tready registered and lets input continue while a
// result waits. Users must write registers over APB while idle; it is not enforced.
`default_nettype none

module length_framed_byte_deframer_unit #(
    parameter int unsigned HEAD_BYTES = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream; tdata: rx_byte[7:0]
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [lfbd_pkg::BYTE_W-1:0]       s_tdata,
    // result stream; tdata: out_byte[7:0]
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [lfbd_pkg::BYTE_W-1:0]            m_tdata,
    // tuser: out_kind[1:0], first_of_frame[2], zero fill [7:3]
    output logic [lfbd_pkg::TUSER_W-1:0]           m_tuser,
    // tlast: last_payload
    output logic                                   m_tlast,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [lfbd_pkg::APB_AW-1:0]       paddr,
    input  wire logic [lfbd_pkg::APB_DW-1:0]       pwdata,
    output logic [lfbd_pkg::APB_DW-1:0]            prdata,
    output logic                                   pready
);

    import lfbd_pkg::*;

    localparam int unsigned IDX_W = (HEAD_BYTES > 1) ? $clog2(HEAD_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HEAD_BYTES - 1);

    // configuration registers
    logic [31:0]        head_pattern_reg;
    logic [BYTE_W-1:0]  tail_value_reg;
    logic [LEN_W-1:0]   min_length_reg;
    logic [LEN_W-1:0]   max_length_reg;

    // frame tracking state
    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   head_idx_reg, head_idx_next;
    logic [BYTE_W-1:0]  len_lo_reg, len_lo_next;
    logic [LEN_W-1:0]   remain_reg, remain_next;
    logic               first_reg, first_next;

    // output stage: result register and skid register
    logic               m_valid_reg;
    logic [BYTE_W-1:0]  m_byte_reg;
    kind_t              m_kind_reg;
    logic               m_first_reg;
    logic               m_last_reg;
    logic               skid_valid_reg;
    logic [BYTE_W-1:0]  skid_byte_reg;
    kind_t              skid_kind_reg;
    logic               skid_first_reg;
    logic               skid_last_reg;

    // result of the current byte
    logic               res_valid;
    kind_t              res_kind;
    logic               res_first;
    logic               res_last;

    logic               s_accept;
    logic               m_take;
    logic               cfg_write;
    logic [1:0]         cfg_idx;
    logic [LEN_W-1:0]   len_full;
    logic               len_bad;
    logic [BYTE_W-1:0]  head_want;

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_take    = m_valid_reg && m_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[3:2];

    assign head_want = head_pattern_reg[8*head_idx_reg +: 8];
    assign len_full  = {s_tdata, len_lo_reg};
    assign len_bad   = (len_full == '0) || (len_full < min_length_reg)
                       || (len_full > max_length_reg);

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_pattern_reg <= '0;
            tail_value_reg   <= '0;
            min_length_reg   <= MIN_LENGTH_RST;
            max_length_reg   <= MAX_LENGTH_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_HEAD_PATTERN: head_pattern_reg <= pwdata;
                REG_TAIL_VALUE:   tail_value_reg   <= pwdata[BYTE_W-1:0];
                REG_MIN_LENGTH:   min_length_reg   <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH:   max_length_reg   <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (cfg_idx)
            REG_HEAD_PATTERN: prdata = head_pattern_reg;
            REG_TAIL_VALUE:   prdata = {{(APB_DW-BYTE_W){1'b0}}, tail_value_reg};
            REG_MIN_LENGTH:   prdata = {{(APB_DW-LEN_W){1'b0}}, min_length_reg};
            REG_MAX_LENGTH:   prdata = {{(APB_DW-LEN_W){1'b0}}, max_length_reg};
            default:          prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        head_idx_next = head_idx_reg;
        len_lo_next   = len_lo_reg;
        remain_next   = remain_reg;
        first_next    = first_reg;
        case (state_reg)
            ST_HEAD: begin
                if (s_tdata != head_want) begin
                    head_idx_next = '0;
                end else if (head_idx_reg == IDX_LAST) begin
                    head_idx_next = '0;
                    state_next    = ST_LEN_LO;
                end else begin
                    head_idx_next = head_idx_reg + 1'b1;
                end
            end
            ST_LEN_LO: begin
                len_lo_next = s_tdata;
                state_next  = ST_LEN_HI;
            end
            ST_LEN_HI: begin
                if (len_bad) begin
                    state_next = ST_HEAD;
                end else begin
                    remain_next = len_full - 1'b1;
                    first_next  = 1'b1;
                    state_next  = ST_BODY;
                end
            end
            ST_BODY: begin
                if (remain_reg == '0) begin
                    state_next = ST_HEAD;
                end else begin
                    remain_next = remain_reg - 1'b1;
                    first_next  = 1'b0;
                end
            end
            default: state_next = ST_HEAD;
        endcase
    end

    // result of this byte
    always_comb begin
        res_valid = 1'b0;
        res_kind  = KIND_PAYLOAD;
        res_first = 1'b0;
        res_last  = 1'b0;
        case (state_reg)
            ST_BODY: begin
                res_valid = 1'b1;
                if (remain_reg == '0) begin
                    res_kind = (s_tdata == tail_value_reg) ? KIND_GOOD : KIND_BAD;
                end else begin
                    res_first = first_reg;
                    res_last  = (remain_reg == LEN_W'(1));
                end
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_HEAD;
            head_idx_reg <= '0;
            first_reg    <= 1'b0;
            remain_reg   <= '0;
        end else if (s_accept) begin
            state_reg    <= state_next;
            head_idx_reg <= head_idx_next;
            first_reg    <= first_next;
            remain_reg   <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            len_lo_reg <= len_lo_next;
        end
    end

    // output stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (s_accept && res_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                m_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_take) begin
                m_byte_reg  <= skid_byte_reg;
                m_kind_reg  <= skid_kind_reg;
                m_first_reg <= skid_first_reg;
                m_last_reg  <= skid_last_reg;
            end
        end else if (s_accept && res_valid) begin
            if (m_valid_reg && !m_tready) begin
                skid_byte_reg  <= s_tdata;
                skid_kind_reg  <= res_kind;
                skid_first_reg <= res_first;
                skid_last_reg  <= res_last;
            end else begin
                m_byte_reg  <= s_tdata;
                m_kind_reg  <= res_kind;
                m_first_reg <= res_first;
                m_last_reg  <= res_last;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = {{(TUSER_W-3){1'b0}}, m_first_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;

    // skid entry only exists behind a held result
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid while result register empty");

    // end words never carry first or last flags
    a_end_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_kind_reg != KIND_PAYLOAD)) |-> (!m_last_reg && !m_first_reg))
        else $error("end word carries a payload flag");

    // tail byte returns to hunting from the first head byte
    a_tail_rehunt: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (state_reg == ST_BODY) && (remain_reg == '0))
        |=> ((state_reg == ST_HEAD) && (head_idx_reg == '0)))
        else $error("no return to hunting after tail");

    // a rejected length gives no result and restarts hunting
    a_len_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (state_reg == ST_LEN_HI) && len_bad)
        |=> (state_reg == ST_HEAD))
        else $error("rejected length did not restart hunting");

    // the last payload word is followed by the tail position
    a_last_then_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && res_valid && res_last) |=> ((state_reg == ST_BODY) && (remain_reg == '0)))
        else $error("last payload not followed by tail position");

endmodule

`default_nettype wire
